>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge, masked while reset is low
`define SWM_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define SWM_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, constants and control types of the sliding window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int POS_BITS   = 16;
    localparam int CFG_BITS   = 7;
    localparam int TOTAL_BITS = 48;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd4;

    localparam logic [TOTAL_BITS-1:0] TOTAL_HI = {1'b0, {(TOTAL_BITS-1){1'b1}}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_LO = {1'b1, {(TOTAL_BITS-1){1'b0}}};

    // per-cycle command to one deque row
    typedef struct packed {
        logic step;
        logic insert;
        logic clear;
    } dq_ctrl_t;

    // flags that travel with one window result
    typedef struct packed {
        logic valid;
        logic full;
        logic last;
    } res_flags_t;

endpackage

`default_nettype wire

>>> rtl/swm_queue.sv
// ----------------------------------------------------------------------------
// swm_queue
// Front end: accepts input transactions, splits out sample and last flag
// and holds them in a two-entry queue for the deque engine.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_queue import swm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int IN_BITS     = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_BITS-1:0]     s_tdata,
    input  wire logic                   s_tlast,
    output logic                        q_valid,
    output logic signed [SAMPLE_BITS-1:0] q_sample,
    output logic                        q_last,
    input  wire logic                   q_pop
);

    logic [SAMPLE_BITS:0] entry_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 push, pop;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_sample = entry_reg[rd_ptr_reg][SAMPLE_BITS-1:0];
    assign q_last   = entry_reg[rd_ptr_reg][SAMPLE_BITS];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= {s_tlast, s_tdata[SAMPLE_BITS-1:0]};
        end
    end

endmodule

`default_nettype wire

>>> rtl/swm_deque.sv
// ----------------------------------------------------------------------------
// swm_deque
// Monotonic deque as a row of cells, front at cell 0. Each step may drop
// one aged front entry; an insert clears every dominated cell in parallel
// and writes the new sample into the first free cell.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_deque import swm_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int K_BITS      = 7,
    parameter bit KEEP_MAX    = 1'b1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dq_ctrl_t                      ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] x,
    input  wire logic [POS_BITS-1:0]           now,
    input  wire logic [K_BITS-1:0]             k,
    output logic                               more_aged,
    output logic signed [SAMPLE_BITS-1:0]      front_new
);

    logic signed [SAMPLE_BITS-1:0] val_reg [DEPTH];
    logic [POS_BITS-1:0]           pos_reg [DEPTH];
    logic [DEPTH-1:0]              valid_reg, valid_next;

    logic signed [SAMPLE_BITS-1:0] sh_val [DEPTH];
    logic [POS_BITS-1:0]           sh_pos [DEPTH];
    logic [DEPTH-1:0]              sh_valid;
    logic [DEPTH-1:0]              dom, keep, wr;
    logic [POS_BITS-1:0]           kx;
    logic                          aged0, aged1;

    assign kx = POS_BITS'(k);

    always_comb begin
        aged0 = valid_reg[0] && ((now - pos_reg[0]) >= kx);
        aged1 = valid_reg[1] && ((now - pos_reg[1]) >= kx);
        for (int i = 0; i < DEPTH; i++) begin
            if (!aged0) begin
                sh_val[i]   = val_reg[i];
                sh_pos[i]   = pos_reg[i];
                sh_valid[i] = valid_reg[i];
            end else if (i < DEPTH-1) begin
                sh_val[i]   = val_reg[i+1];
                sh_pos[i]   = pos_reg[i+1];
                sh_valid[i] = valid_reg[i+1];
            end else begin
                sh_val[i]   = val_reg[i];
                sh_pos[i]   = pos_reg[i];
                sh_valid[i] = 1'b0;
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            dom[i]  = sh_valid[i] && (KEEP_MAX ? (sh_val[i] <= x) : (sh_val[i] >= x));
            keep[i] = sh_valid[i] && !dom[i];
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                wr[i] = !keep[0];
            end else begin
                wr[i] = !keep[i] && keep[i-1];
            end
        end
        more_aged = aged0 && aged1;
        front_new = keep[0] ? sh_val[0] : x;

        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else if (ctrl.insert) begin
            valid_next = keep | wr;
        end else if (ctrl.step) begin
            valid_next = sh_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (ctrl.insert) begin
                val_reg[i] <= wr[i] ? x : sh_val[i];
                pos_reg[i] <= wr[i] ? now : sh_pos[i];
            end else if (ctrl.step) begin
                val_reg[i] <= sh_val[i];
                pos_reg[i] <= sh_pos[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/swm_engine.sv
// ----------------------------------------------------------------------------
// swm_engine
// Back end: ages and updates the max and min deques for the queued sample,
// tracks position and fill count and registers the window extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_engine import swm_pkg::*; #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [CFG_BITS-1:0]           window_size,
    input  wire logic                          q_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] q_sample,
    input  wire logic                          q_last,
    output logic                               q_pop,
    input  wire logic                          r_ready,
    output res_flags_t                         r_flags,
    output logic signed [SAMPLE_BITS-1:0]      r_wmax,
    output logic signed [SAMPLE_BITS-1:0]      r_wmin
);

    localparam int SW = $clog2(WINDOW_MAX + 1);
    localparam int WW = (SW > CFG_BITS) ? SW : CFG_BITS;

    logic [SW-1:0]       seen_reg, seen_next, seen_inc;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [WW-1:0]       ws_ext;
    logic [SW-1:0]       k;
    logic                go, more, full;
    dq_ctrl_t            ctrl;
    logic                max_more, min_more;
    logic signed [SAMPLE_BITS-1:0] max_front, min_front;

    res_flags_t                    flags_reg, flags_next;
    logic signed [SAMPLE_BITS-1:0] wmax_reg, wmin_reg;

    assign ws_ext = WW'(window_size);

    always_comb begin
        if (ws_ext == '0) begin
            k = SW'(1);
        end else if (ws_ext > WW'(WINDOW_MAX)) begin
            k = SW'(WINDOW_MAX);
        end else begin
            k = ws_ext[SW-1:0];
        end
    end

    assign go          = q_valid && (!flags_reg.valid || r_ready);
    assign more        = max_more || min_more;
    assign ctrl.step   = go;
    assign ctrl.insert = go && !more;
    assign ctrl.clear  = go && !more && q_last;
    assign q_pop       = ctrl.insert;

    assign seen_inc = (seen_reg == SW'(WINDOW_MAX)) ? seen_reg : seen_reg + SW'(1);
    assign full     = (seen_inc >= k);

    always_comb begin
        seen_next  = seen_reg;
        pos_next   = pos_reg;
        flags_next = flags_reg;
        if (r_ready) begin
            flags_next.valid = 1'b0;
        end
        if (ctrl.insert) begin
            seen_next  = q_last ? '0 : seen_inc;
            pos_next   = q_last ? '0 : pos_reg + POS_BITS'(1);
            flags_next = '{valid: 1'b1, full: full, last: q_last};
        end
    end

    swm_deque #(
        .DEPTH       (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .K_BITS      (SW),
        .KEEP_MAX    (1'b1)
    ) u_max_dq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .x         (q_sample),
        .now       (pos_reg),
        .k         (k),
        .more_aged (max_more),
        .front_new (max_front)
    );

    swm_deque #(
        .DEPTH       (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .K_BITS      (SW),
        .KEEP_MAX    (1'b0)
    ) u_min_dq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .x         (q_sample),
        .now       (pos_reg),
        .k         (k),
        .more_aged (min_more),
        .front_new (min_front)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            pos_reg   <= '0;
            flags_reg <= '0;
        end else begin
            seen_reg  <= seen_next;
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.insert) begin
            wmax_reg <= full ? max_front : '0;
            wmin_reg <= full ? min_front : '0;
        end
    end

    assign r_flags = flags_reg;
    assign r_wmax  = wmax_reg;
    assign r_wmin  = wmin_reg;

endmodule

`default_nettype wire

>>> rtl/swm_accum.sv
// ----------------------------------------------------------------------------
// swm_accum
// Adds each full window's max plus min to the saturating running total
// and holds the result transaction in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_accum import swm_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire res_flags_t                    r_flags,
    input  wire logic signed [SAMPLE_BITS-1:0] r_wmax,
    input  wire logic signed [SAMPLE_BITS-1:0] r_wmin,
    output logic                               r_ready,
    output logic                               o_valid,
    input  wire logic                          o_ready,
    output logic [SAMPLE_BITS-1:0]             o_wmax,
    output logic [SAMPLE_BITS-1:0]             o_wmin,
    output logic                               o_full,
    output logic [TOTAL_BITS-1:0]              o_total,
    output logic                               o_last
);

    logic [TOTAL_BITS-1:0]        total_reg, total_next;
    logic                         valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0]       wmax_reg, wmin_reg;
    logic                         full_reg, last_reg;
    logic [TOTAL_BITS-1:0]        out_total_reg;
    logic signed [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0]        sat, new_total;
    logic                         take;

    assign r_ready = !valid_reg || o_ready;
    assign take    = r_flags.valid && r_ready;

    always_comb begin
        sum = $signed({total_reg[TOTAL_BITS-1], total_reg})
            + (TOTAL_BITS+1)'(r_wmax) + (TOTAL_BITS+1)'(r_wmin);
        if (sum[TOTAL_BITS] != sum[TOTAL_BITS-1]) begin
            sat = sum[TOTAL_BITS] ? TOTAL_LO : TOTAL_HI;
        end else begin
            sat = sum[TOTAL_BITS-1:0];
        end
        new_total  = r_flags.full ? sat : total_reg;
        total_next = total_reg;
        valid_next = valid_reg;
        if (o_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            total_next = r_flags.last ? '0 : new_total;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            wmax_reg      <= r_wmax;
            wmin_reg      <= r_wmin;
            full_reg      <= r_flags.full;
            last_reg      <= r_flags.last;
            out_total_reg <= new_total;
        end
    end

    assign o_valid = valid_reg;
    assign o_wmax  = wmax_reg;
    assign o_wmin  = wmin_reg;
    assign o_full  = full_reg;
    assign o_total = out_total_reg;
    assign o_last  = last_reg;

endmodule

`default_nettype wire

>>> rtl/sliding_window_min_max_sum_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_sum_unit
// Sliding window maximum and minimum with a saturating running sum.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one signed sample per transaction, s_tlast ends a
//   sequence. m_ channel returns one result per sample: window max, min,
//   running total, window full flag on m_tuser, copy of last on m_tlast.
//   cfg_we/cfg_wdata set window_size (clamped to 1..WINDOW_MAX); write
//   only while no transaction is in flight.
//   a sample passes the queue, engine and output registers to m_tvalid.
//   throughput: 1 sample per cycle while m_ is not stalled, set by the
//   single step of the deque cell rows; each extra aged front entry after
//   window_size shrinks adds a deque step that takes no sample.
//   reset: empties deques, clears position, fill count, total and all
//   valid flags; window_size returns to 4. A last transaction clears the
//   deques, position, fill count and total after its result, window_size kept.
//   stall: m_ holds its result, the engine and a two-entry input queue
//   fill up, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max_sum_unit import swm_pkg::*; #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [CFG_BITS-1:0] cfg_wdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // window_max, window_min, total
    output logic [((2*SAMPLE_BITS+TOTAL_BITS+7)/8)*8-1:0] m_tdata,
    // window_full
    output logic [0:0]               m_tuser,
    output logic                     m_tlast
);

    localparam int IN_BITS  = ((SAMPLE_BITS+7)/8)*8;
    localparam int OUT_BITS = ((2*SAMPLE_BITS+TOTAL_BITS+7)/8)*8;

    logic [CFG_BITS-1:0]           window_size_reg;
    logic                          q_valid, q_last, q_pop;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    res_flags_t                    r_flags;
    logic signed [SAMPLE_BITS-1:0] r_wmax, r_wmin;
    logic                          r_ready;
    logic [SAMPLE_BITS-1:0]        o_wmax, o_wmin;
    logic [TOTAL_BITS-1:0]         o_total;
    logic                          o_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= CFG_RESET;
        end else if (cfg_we) begin
            window_size_reg <= cfg_wdata;
        end
    end

    swm_queue #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_BITS     (IN_BITS)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_sample (q_sample),
        .q_last   (q_last),
        .q_pop    (q_pop)
    );

    swm_engine #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .window_size (window_size_reg),
        .q_valid     (q_valid),
        .q_sample    (q_sample),
        .q_last      (q_last),
        .q_pop       (q_pop),
        .r_ready     (r_ready),
        .r_flags     (r_flags),
        .r_wmax      (r_wmax),
        .r_wmin      (r_wmin)
    );

    swm_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .r_flags (r_flags),
        .r_wmax  (r_wmax),
        .r_wmin  (r_wmin),
        .r_ready (r_ready),
        .o_valid (m_tvalid),
        .o_ready (m_tready),
        .o_wmax  (o_wmax),
        .o_wmin  (o_wmin),
        .o_full  (o_full),
        .o_total (o_total),
        .o_last  (m_tlast)
    );

    assign m_tdata    = OUT_BITS'({o_total, o_wmin, o_wmax});
    assign m_tuser[0] = o_full;

endmodule

`default_nettype wire

>>> rtl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the result channel of the sliding window unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swm_checker import swm_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [((2*SAMPLE_BITS+TOTAL_BITS+7)/8)*8-1:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tlast
);

    localparam int SB = SAMPLE_BITS;

    `SWM_ASSERT_CLK(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    `SWM_ASSERT_RST(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    `SWM_ASSERT_RST(a_partial_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata[2*SB-1:0] == '0, "extremes not zero before window full")

    `SWM_ASSERT_RST(a_max_ge_min, aclk, aresetn, m_tvalid && m_tuser[0] |-> $signed(m_tdata[SB-1:0]) >= $signed(m_tdata[2*SB-1:SB]), "window max below window min")

endmodule

bind sliding_window_min_max_sum_unit swm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the sliding window max/min/sum unit.
// ----------------------------------------------------------------------------
// Samples are streamed in sequences ended by s_tlast. A predictor keeps its
// own pair of monotonic deques, the fill count, the sample position and the
// saturating total. It queues one expected window result for every accepted
// input transaction. A checker compares each output transaction field by
// field with the oldest queued result. The run covers directed extremes,
// window sizes at and beyond their limits, resizing inside a sequence, a
// long output stall, and random sequences with idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb import swm_pkg::*; ();

    localparam int SAMPLE_W    = 16;
    localparam int WIN_LIMIT   = 64;
    localparam int S_W         = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_W         = ((2 * SAMPLE_W + TOTAL_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 40;
    localparam int EXP_AW      = 4;
    localparam int EXP_DEPTH   = 1 << EXP_AW;
    localparam longint SUM_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO  = -SUM_HI - 1;

    typedef enum int {
        PAT_RANDOM,
        PAT_RISING,
        PAT_FALLING,
        PAT_NARROW,
        PAT_EXTREME
    } pattern_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]   wmax;
        logic signed [SAMPLE_W-1:0]   wmin;
        logic                         full;
        logic signed [TOTAL_BITS-1:0] total;
        logic                         lst;
    } win_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_BITS-1:0]   cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_W-1:0]        m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    // predictor state
    logic signed [SAMPLE_W-1:0]   dq_val [2][WIN_LIMIT];
    logic [15:0]                  dq_pos [2][WIN_LIMIT];
    int                           dq_cnt [2];
    logic [15:0]                  pos_ctr;
    logic signed [TOTAL_BITS-1:0] run_total;
    int                           seen;
    logic [CFG_BITS-1:0]          win_reg;

    win_result_t                  exp_ring [EXP_DEPTH];
    int                           exp_wr_cnt;
    int                           exp_rd_cnt;
    win_result_t                  want;
    logic signed [SAMPLE_W-1:0]   ramp_val;
    int                           err_count;
    int                           sample_count;
    int                           cycle_count;
    int                           sink_hold;
    bit                           idle_on;

    sliding_window_min_max_sum_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void exp_store(input win_result_t r);
        exp_ring[exp_wr_cnt[EXP_AW-1:0]] = r;
        exp_wr_cnt++;
    endfunction

    function automatic win_result_t exp_fetch();
        win_result_t r;
        r = exp_ring[exp_rd_cnt[EXP_AW-1:0]];
        exp_rd_cnt++;
        return r;
    endfunction

    function automatic void clear_window_state();
        dq_cnt[0] = 0;
        dq_cnt[1] = 0;
        pos_ctr   = '0;
        run_total = '0;
        seen      = 0;
    endfunction

    // d = 0 tracks the maximum, d = 1 the minimum
    function automatic win_result_t compute_window_result(
        input logic signed [SAMPLE_W-1:0] x,
        input logic                       lst
    );
        win_result_t                r;
        int                         k;
        int                         d;
        int                         j;
        logic [15:0]                age;
        logic signed [SAMPLE_W-1:0] tail;
        bit                         busy;
        longint                     acc;
        k = int'(win_reg);
        if (k < 1) k = 1;
        if (k > WIN_LIMIT) k = WIN_LIMIT;
        for (d = 0; d < 2; d++) begin
            busy = 1'b1;
            while (busy && dq_cnt[d] > 0) begin
                age = pos_ctr - dq_pos[d][0];
                if (int'(age) >= k) begin
                    for (j = 1; j < dq_cnt[d]; j++) begin
                        dq_val[d][j-1] = dq_val[d][j];
                        dq_pos[d][j-1] = dq_pos[d][j];
                    end
                    dq_cnt[d]--;
                end else begin
                    busy = 1'b0;
                end
            end
            busy = 1'b1;
            while (busy && dq_cnt[d] > 0) begin
                tail = dq_val[d][dq_cnt[d]-1];
                if ((d == 0) ? (tail <= x) : (tail >= x)) begin
                    dq_cnt[d]--;
                end else begin
                    busy = 1'b0;
                end
            end
            dq_val[d][dq_cnt[d]] = x;
            dq_pos[d][dq_cnt[d]] = pos_ctr;
            dq_cnt[d]++;
        end
        if (seen < WIN_LIMIT) seen++;
        pos_ctr = pos_ctr + 16'd1;
        r.full = (seen >= k);
        r.wmax = '0;
        r.wmin = '0;
        if (r.full) begin
            r.wmax = dq_val[0][0];
            r.wmin = dq_val[1][0];
            acc = longint'(run_total) + longint'(r.wmax) + longint'(r.wmin);
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
            run_total = acc[TOTAL_BITS-1:0];
        end
        r.total = run_total;
        r.lst   = lst;
        if (lst) clear_window_state();
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] next_sample(input pattern_t pat);
        logic signed [SAMPLE_W-1:0] v;
        case (pat)
            PAT_RISING: begin
                ramp_val = ramp_val + SAMPLE_W'($urandom_range(1, 40));
                v = ramp_val;
            end
            PAT_FALLING: begin
                ramp_val = ramp_val - SAMPLE_W'($urandom_range(1, 40));
                v = ramp_val;
            end
            PAT_NARROW: begin
                v = SAMPLE_W'($urandom_range(0, 6)) - 16'sd3;
            end
            PAT_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = 16'sh0000;
                    default: v = 16'shFFFF;
                endcase
            end
            default: begin
                v = SAMPLE_W'($urandom);
            end
        endcase
        return v;
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_window();
        logic [CFG_BITS-1:0] w;
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = CFG_BITS'(1);
            2: w = CFG_BITS'(WIN_LIMIT);
            3: w = CFG_BITS'(WIN_LIMIT + 1);
            4: w = '1;
            5, 6: w = CFG_BITS'($urandom_range(2, 8));
            7: w = CFG_BITS'($urandom_range(9, WIN_LIMIT - 1));
            default: w = CFG_BITS'($urandom_range(0, 127));
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint exp_v);
        if (err_count < MAX_REPORTS) begin
            $display("%0t ns: mismatch on %s, got %0d expected %0d", $realtime, field, got, exp_v);
        end
        err_count++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        exp_store(compute_window_result(smp, lst));
        sample_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (exp_wr_cnt != exp_rd_cnt) @(posedge aclk);
    endtask

    task automatic set_window(input logic [CFG_BITS-1:0] w);
        wait_drained();
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        win_reg = w;
    endtask

    task automatic run_sequence(input int len, input bit close);
        pattern_t pat;
        int       i;
        pat      = pattern_t'($urandom_range(0, 4));
        ramp_val = SAMPLE_W'($urandom);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 31) == 0) pat = pattern_t'($urandom_range(0, 4));
            send_sample(next_sample(pat), close && (i == len - 1));
        end
    endtask

    task automatic test_reset_window();
        idle_on = 1'b1;
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(-16'sd5, 1'b1);
    endtask

    task automatic test_window_limits();
        set_window(CFG_BITS'(1));
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        set_window('0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd5, 1'b1);
        set_window('1);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b1);
        set_window(CFG_BITS'(WIN_LIMIT));
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
    endtask

    // shrink ages several entries at once, growing recomputes the full flag
    task automatic test_resize_mid_sequence();
        set_window(CFG_BITS'(8));
        send_sample(16'sd50, 1'b0);
        send_sample(16'sd40, 1'b0);
        send_sample(-16'sd30, 1'b0);
        send_sample(16'sd20, 1'b0);
        send_sample(-16'sd10, 1'b0);
        send_sample(16'sd10, 1'b0);
        set_window(CFG_BITS'(2));
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd3, 1'b0);
        set_window(CFG_BITS'(5));
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd0, 1'b1);
    endtask

    task automatic test_output_stall();
        idle_on   = 1'b0;
        sink_hold = 300;
        run_sequence(40, 1'b1);
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_sequences();
        int goal;
        int seq_len;
        goal = sample_count + 1700;
        while (sample_count < goal) begin
            idle_on = (goal - sample_count > 300) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) set_window(pick_window());
            case ($urandom_range(0, 3))
                0: seq_len = $urandom_range(1, 8);
                1, 2: seq_len = $urandom_range(5, 40);
                default: seq_len = $urandom_range(60, 160);
            endcase
            if ($urandom_range(0, 7) == 0) begin
                run_sequence(seq_len, 1'b0);
                set_window(pick_window());
                run_sequence($urandom_range(1, 40), 1'b1);
            end else begin
                run_sequence(seq_len, 1'b1);
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        err_count    = 0;
        sample_count = 0;
        sink_hold    = 0;
        idle_on      = 1'b1;
        ramp_val     = '0;
        exp_wr_cnt   = 0;
        exp_rd_cnt   = 0;
        clear_window_state();
        win_reg = CFG_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_window();
        test_window_limits();
        test_resize_mid_sequence();
        test_output_stall();
        test_random_sequences();
        wait_drained();
        repeat (16) @(posedge aclk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // output side ready, with idle bursts and one long hold
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // m_tdata: window_max, window_min, total from the lowest bit up
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_wr_cnt == exp_rd_cnt) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = exp_fetch();
                if (m_tdata[SAMPLE_W-1:0] !== want.wmax)
                    report_mismatch("window_max", $signed(m_tdata[SAMPLE_W-1:0]), want.wmax);
                if (m_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.wmin)
                    report_mismatch("window_min", $signed(m_tdata[2*SAMPLE_W-1:SAMPLE_W]),
                                    want.wmin);
                if (m_tdata[2*SAMPLE_W+TOTAL_BITS-1:2*SAMPLE_W] !== want.total)
                    report_mismatch("total",
                                    $signed(m_tdata[2*SAMPLE_W+TOTAL_BITS-1:2*SAMPLE_W]),
                                    want.total);
                if (m_tuser[0] !== want.full)
                    report_mismatch("window_full", m_tuser[0], want.full);
                if (m_tlast !== want.lst)
                    report_mismatch("last", m_tlast, want.lst);
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
